[src/fem_pkg.sv]
`default_nettype none
package fem_pkg;
  typedef enum logic [1:0] {
    MODE_RECORD = 2'd0,
    MODE_CLOSE  = 2'd1,
    MODE_QUERY  = 2'd2,
    MODE_NONE   = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    REG_TARGET  = 2'd0,
    REG_MIN_TXN = 2'd1,
    REG_MIN_MUL = 2'd2,
    REG_NONE    = 2'd3
  } reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_INS,
    ST_MED,
    ST_QMUL,
    ST_OUT
  } state_e;

  localparam logic [63:0] ALL_ONES   = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] BASE_LEVEL = 64'd256;

  // Insertion sweep control broadcast to every cell of the row.
  typedef struct packed {
    logic        shift;
    logic [63:0] level;
  } ins_ctl_t;
endpackage
`default_nettype wire

[src/fee_escalation_metrics_unit.sv]
`default_nettype none
// Fee escalation metrics. A record word (mode 0) turns fee*256/base into a
// fee level through a bit-serial divider and then inserts it into a row of
// LEDGER_CAPACITY sorted cells; the input is busy until the insert is done.
// A pseudo record or a zero base skips the divider. A full row drops the
// word and sets the overflow flag, and the input stays ready. A close word
// (mode 1) updates the expected count, takes the rounded median of the row,
// at least the minimum multiplier, as the new multiplier and empties the row.
// A query word (mode 2) with an open count above the expected count forms
// n*n*mult in three steps and divides 256*n*n*mult by expected^2 in the same
// divider, or gives all ones if expected is zero. A query with no more than
// that gives the base level. One word is in work at a time. A result sits in
// an output register until taken. A close or query word whose result is
// ready holds in its last step while an older result still waits, so each
// word can add a wait of the receiver's stall.
module fee_escalation_metrics_unit #(
  parameter int unsigned LEDGER_CAPACITY = 256
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [31:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  mode_i,
  input  wire logic [56:0] fee_drops_i,
  input  wire logic [56:0] base_fee_drops_i,
  input  wire logic        is_pseudo_i,
  input  wire logic        time_leap_i,
  input  wire logic [15:0] open_count_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [63:0]      required_level_o,
  output logic [15:0]      expected_count_o,
  output logic [31:0]      multiplier_now_o,
  output logic [15:0]      ledger_size_o,
  output logic             store_overflow_o
);
  localparam int unsigned CW = $clog2(LEDGER_CAPACITY + 1);
  localparam int unsigned IW = (LEDGER_CAPACITY > 1) ? $clog2(LEDGER_CAPACITY) : 1;

  // configuration registers
  logic [15:0] target_q, min_txn_q;
  logic [31:0] min_mul_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= 16'd50; min_txn_q <= 16'd5; min_mul_q <= 32'd500;
    end else if (cfg_we_i) begin
      case (fem_pkg::reg_e'(cfg_index_i))
        fem_pkg::REG_TARGET:  target_q  <= cfg_data_i[15:0];
        fem_pkg::REG_MIN_TXN: min_txn_q <= cfg_data_i[15:0];
        fem_pkg::REG_MIN_MUL: min_mul_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  fem_pkg::state_e state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic          ovf_q, ovf_d;
  logic [15:0]   exp_q, exp_d;
  logic [31:0]   mult_q, mult_d;
  logic [63:0]   level_q, level_d;
  logic [15:0]   n_q;
  logic          leap_q;
  logic [1:0]    qstep_q, qstep_d;
  logic [63:0]   prod_q, prod_d;
  logic [31:0]   den_q, den_d;
  logic          ovalid_q, ovalid_d;
  logic [63:0]   oreq_q, oreq_d;
  logic [15:0]   oexp_q, oexp_d, osize_q, osize_d;
  logic [31:0]   omul_q, omul_d;
  logic          oovf_q, oovf_d;
  logic [63:0]   med_a_q, med_b_q;

  logic          accept;
  logic          div_start, div_done;
  logic [119:0]  div_num;
  logic [63:0]   div_den, div_quo;
  fem_pkg::ins_ctl_t ctl;

  assign in_ready_o = (state_q == fem_pkg::ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  // row of sorted cells
  logic [63:0] val  [LEDGER_CAPACITY];
  logic        gt   [LEDGER_CAPACITY];
  assign ctl.shift = (state_q == fem_pkg::ST_INS);
  assign ctl.level = level_q;

  for (genvar g = 0; g < LEDGER_CAPACITY; g++) begin : g_row
    logic        lgt;
    logic [63:0] lval;
    if (g == 0) begin : g_first
      assign lgt = 1'b0; assign lval = '0;
    end else begin : g_rest
      assign lgt = gt[g-1]; assign lval = val[g-1];
    end
    fem_cell u_cell (
      .clk_i, .ctl_i(ctl), .left_gt_i(lgt), .left_val_i(lval),
      .used_i(CW'(g) < count_q), .gt_o(gt[g]), .val_o(val[g])
    );
  end

  // median pick: registered read of two slots
  logic [IW-1:0] ia, ib;
  logic [CW-1:0] cm1;
  assign cm1 = count_q - CW'(1);
  assign ia  = IW'(count_q >> 1);
  assign ib  = IW'(cm1 >> 1);
  always_ff @(posedge clk_i) begin
    med_a_q <= val[ia];
    med_b_q <= val[ib];
  end

  fem_divider u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(div_num), .den_i(div_den),
    .done_o(div_done), .quo_o(div_quo)
  );

  logic [64:0] med_sum;
  logic [63:0] med;
  logic [15:0] lim, emax, sz16;
  logic [31:0] msat;
  assign med_sum = {1'b0, med_a_q} + {1'b0, med_b_q} + 65'd1;
  assign med     = med_sum[64:1];
  assign msat    = (med[63:32] != 0) ? 32'hFFFF_FFFF : med[31:0];
  assign lim     = target_q - 16'd1;
  assign sz16    = 16'(count_q);
  assign emax    = (sz16 > min_txn_q) ? sz16 : min_txn_q;

  // divider start: a non-pseudo record with nonzero base and room in the row, or the last query step with den != 0
  always_comb begin
    div_start = 1'b0;
    div_num   = {48'd0, prod_q, 8'd0};
    div_den   = {32'd0, den_q};
    unique case (state_q)
      fem_pkg::ST_IDLE: begin
        if (accept && fem_pkg::mode_e'(mode_i) == fem_pkg::MODE_RECORD &&
            count_q < CW'(LEDGER_CAPACITY) && !is_pseudo_i &&
            base_fee_drops_i != '0) begin
          div_start = 1'b1;
          div_num   = {55'd0, fee_drops_i, 8'd0};
          div_den   = {7'd0, base_fee_drops_i};
        end
      end
      fem_pkg::ST_QMUL: begin
        if (qstep_q == 2'd2 && den_q != '0) div_start = 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    state_d = state_q; count_d = count_q; ovf_d = ovf_q; exp_d = exp_q;
    mult_d = mult_q; level_d = level_q; qstep_d = qstep_q;
    prod_d = prod_q; den_d = den_q;
    ovalid_d = ovalid_q && !out_ready_i;
    oreq_d = oreq_q; oexp_d = oexp_q; omul_d = omul_q;
    osize_d = osize_q; oovf_d = oovf_q;
    unique case (state_q)
      fem_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (fem_pkg::mode_e'(mode_i))
            fem_pkg::MODE_RECORD: begin
              if (count_q >= CW'(LEDGER_CAPACITY)) begin
                ovf_d = 1'b1;
              end else if (is_pseudo_i || base_fee_drops_i == '0) begin
                level_d = fem_pkg::ALL_ONES; state_d = fem_pkg::ST_INS;
              end else begin
                state_d = fem_pkg::ST_DIV;
              end
            end
            fem_pkg::MODE_CLOSE: state_d = fem_pkg::ST_MED;
            fem_pkg::MODE_QUERY: begin
              if (open_count_i > exp_q) begin
                qstep_d = 2'd0; state_d = fem_pkg::ST_QMUL;
              end else begin
                level_d = fem_pkg::BASE_LEVEL; state_d = fem_pkg::ST_OUT;
              end
            end
            default: ;
          endcase
        end
      end
      fem_pkg::ST_DIV: begin
        if (div_done) begin
          level_d = div_quo;
          state_d = prod_q[0] ? fem_pkg::ST_OUT : fem_pkg::ST_INS;
        end
      end
      fem_pkg::ST_INS: begin
        count_d = count_q + CW'(1); state_d = fem_pkg::ST_IDLE;
      end
      fem_pkg::ST_MED: begin
        // close: hold until the output register is free; the row and the
        // count keep the closed ledger, so the median pick stays valid
        if (!ovalid_d) begin
          if (leap_q) begin
            exp_d = (emax < lim) ? emax : lim;
          end else if (sz16 > exp_q || sz16 > target_q) begin
            exp_d = sz16;
          end
          if (count_q == '0) mult_d = min_mul_q;
          else               mult_d = (msat > min_mul_q) ? msat : min_mul_q;
          oreq_d = '0; osize_d = sz16; oovf_d = ovf_q;
          oexp_d = exp_d; omul_d = mult_d;
          count_d = '0; ovf_d = 1'b0;
          ovalid_d = 1'b1; state_d = fem_pkg::ST_IDLE;
        end
      end
      fem_pkg::ST_QMUL: begin
        // n*n, then *mult; den = e*e; then divide (n*n*mult*256)/(e*e)
        qstep_d = qstep_q + 2'd1;
        if (qstep_q == 2'd0) begin
          prod_d = {32'd0, 32'(n_q) * 32'(n_q)};
          den_d  = 32'(exp_q) * 32'(exp_q);
        end else if (qstep_q == 2'd1) begin
          prod_d = prod_q[31:0] * 64'(mult_q);
        end else begin
          if (den_q == '0) begin
            level_d = fem_pkg::ALL_ONES; state_d = fem_pkg::ST_OUT;
          end else begin
            state_d = fem_pkg::ST_DIV;
          end
        end
      end
      fem_pkg::ST_OUT: begin
        // query result: hold the level until the output register is free
        if (!ovalid_d) begin
          ovalid_d = 1'b1;
          oreq_d = level_q; oexp_d = exp_q; omul_d = mult_q;
          osize_d = sz16; oovf_d = ovf_q;
          state_d = fem_pkg::ST_IDLE;
        end
      end
      default: state_d = fem_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fem_pkg::ST_IDLE; count_q <= '0; ovf_q <= 1'b0;
      exp_q <= 16'd5; mult_q <= 32'd500; ovalid_q <= 1'b0; qstep_q <= '0;
    end else begin
      state_q <= state_d; count_q <= count_d; ovf_q <= ovf_d;
      exp_q <= exp_d; mult_q <= mult_d; ovalid_q <= ovalid_d; qstep_q <= qstep_d;
    end
  end

  always_ff @(posedge clk_i) begin
    level_q <= level_d; den_q <= den_d;
    oreq_q <= oreq_d; oexp_q <= oexp_d; omul_q <= omul_d;
    osize_q <= osize_d; oovf_q <= oovf_d;
    if (accept) begin
      n_q <= open_count_i; leap_q <= time_leap_i;
    end
    // bit 0 of prod_q marks a query once its division has started
    if (div_start) prod_q <= {63'd0, state_q == fem_pkg::ST_QMUL};
    else           prod_q <= prod_d;
  end

  assign out_valid_o      = ovalid_q;
  assign required_level_o = oreq_q;
  assign expected_count_o = oexp_q;
  assign multiplier_now_o = omul_q;
  assign ledger_size_o    = osize_q;
  assign store_overflow_o = oovf_q;
endmodule
`default_nettype wire

[src/fem_cell.sv]
`default_nettype none
// One slot of the sorted row. On a shift, a used slot keeps its value if it
// is not above the new level; otherwise it takes the new level if its left
// neighbor is not above it, and else takes its left neighbor's value.
module fem_cell (
  input  wire logic             clk_i,
  input  wire fem_pkg::ins_ctl_t ctl_i,
  input  wire logic             left_gt_i,
  input  wire logic [63:0]      left_val_i,
  input  wire logic             used_i,
  output logic                  gt_o,
  output logic [63:0]           val_o
);
  logic [63:0] val_q, val_d;

  assign gt_o  = used_i && (val_q > ctl_i.level);
  assign val_o = val_q;

  always_comb begin
    val_d = val_q;
    if (ctl_i.shift && (gt_o || !used_i)) begin
      if (left_gt_i) val_d = left_val_i;
      else           val_d = ctl_i.level;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end
endmodule
`default_nettype wire

[src/fem_divider.sv]
`default_nettype none
// Restoring divider: quotient of a 120-bit dividend by a 64-bit divisor,
// one bit a cycle. Only the low 64 quotient bits are kept, saturating.
module fem_divider (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         start_i,
  input  wire logic [119:0] num_i,
  input  wire logic [63:0]  den_i,
  output logic              done_o,
  output logic [63:0]       quo_o
);
  localparam int unsigned NB = 120;
  logic [119:0] num_q, num_d;
  logic [64:0]  rem_q, rem_d;
  logic [63:0]  den_q, den_d;
  logic [63:0]  quo_q, quo_d;
  logic         sat_q, sat_d;
  logic [6:0]   cnt_q, cnt_d;
  logic         busy_q, busy_d;
  logic [65:0]  trial;

  always_comb begin
    num_d = num_q; rem_d = rem_q; den_d = den_q; quo_d = quo_q;
    sat_d = sat_q; cnt_d = cnt_q; busy_d = busy_q;
    trial = {rem_q, num_q[NB-1]} - {2'b0, den_q};
    if (start_i) begin
      num_d = num_i; rem_d = '0; den_d = den_i; quo_d = '0;
      sat_d = 1'b0; cnt_d = 7'(NB); busy_d = 1'b1;
    end else if (busy_q) begin
      num_d = {num_q[NB-2:0], 1'b0};
      if (!trial[65]) begin
        rem_d = trial[64:0];
      end else begin
        rem_d = {rem_q[63:0], num_q[NB-1]};
      end
      sat_d = sat_q | quo_q[63];
      quo_d = {quo_q[62:0], !trial[65]};
      cnt_d = cnt_q - 7'd1;
      if (cnt_q == 7'd1) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d; rem_q <= rem_d; den_q <= den_d;
    quo_q <= quo_d; sat_q <= sat_d;
  end

  assign done_o = busy_q && (cnt_q == 7'd1);
  assign quo_o  = (sat_q | quo_q[63]) ? fem_pkg::ALL_ONES
                                      : {quo_q[62:0], !trial[65]};
endmodule
`default_nettype wire

[src/fem_checker.sv]
`default_nettype none
module fem_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_o,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [63:0] required_level_o,
  input wire logic [15:0] ledger_size_o
);
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(required_level_o)
                                    && $stable(ledger_size_o))
    else $error("result dropped while stalled");
  a_known_handshake: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$isunknown({in_ready_o, out_valid_o}))
    else $error("unknown handshake");
  a_size_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ledger_size_o <= 16'd4096)
    else $error("ledger size out of range");
endmodule
bind fee_escalation_metrics_unit fem_checker u_fem_checker (.*);
`default_nettype wire

[test/tb_fee_escalation_metrics_unit.sv]
`default_nettype none
module tb_fee_escalation_metrics_unit;

  localparam int unsigned CAPACITY    = 256;
  // Cycles without an accepted word, a taken result or a register write before the run is declared hung.
  localparam int unsigned STALL_LIMIT = 5000;
  // Quiet time before a register write: a record word has no result to
  // wait for and may still be in the divider or the insert.
  localparam int unsigned SETTLE      = 200;

  typedef struct {
    fem_pkg::mode_e mode;
    logic [56:0]    fee;
    logic [56:0]    base;
    logic           pseudo;
    logic           leap;
    logic [15:0]    open_n;
  } word_t;

  typedef struct {
    logic [63:0] required;
    logic [15:0] expected;
    logic [31:0] mult;
    logic [15:0] size;
    logic        ovf;
  } metrics_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_index_i = 2'd0;
  logic [31:0] cfg_data_i = 32'd0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  mode_i = 2'd0;
  logic [56:0] fee_drops_i = '0;
  logic [56:0] base_fee_drops_i = '0;
  logic        is_pseudo_i = 1'b0;
  logic        time_leap_i = 1'b0;
  logic [15:0] open_count_i = 16'd0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [63:0] required_level_o;
  logic [15:0] expected_count_o;
  logic [31:0] multiplier_now_o;
  logic [15:0] ledger_size_o;
  logic        store_overflow_o;

  fee_escalation_metrics_unit #(.LEDGER_CAPACITY(CAPACITY)) dut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Predictor state: its own copy of the registers and of the ledger store.
  logic [15:0] target_reg = 16'd50;
  logic [15:0] min_txn_reg = 16'd5;
  logic [31:0] min_mul_reg = 32'd500;
  logic [63:0] fee_levels [CAPACITY];
  int unsigned level_cnt = 0;
  logic        dropped = 1'b0;
  logic [15:0] exp_txns = 16'd5;
  logic [31:0] esc_mult = 32'd500;

  word_t       pending_words[$];
  metrics_t    expected_metrics[$];
  bit          failed = 1'b0;
  bit          word_taken = 1'b0;
  bit          metrics_taken = 1'b0;
  int unsigned idle_cycles = 0;
  int unsigned words_queued = 0;

  // floor(num*256/den), saturating to 64 bits.
  function automatic logic [63:0] scale_256(logic [127:0] num, logic [127:0] den);
    logic [127:0] quo;
    quo = num / den;
    if (quo >= (128'd1 << 56)) return fem_pkg::ALL_ONES;
    return 64'((num << 8) / den);
  endfunction

  function automatic void predict_word(word_t w);
    logic [63:0]  lvl;
    logic [64:0]  med;
    logic [31:0]  med32;
    logic [31:0]  lim;
    logic [31:0]  grown;
    logic [127:0] num;
    logic [127:0] den;
    int unsigned  pos;
    int unsigned  size;
    logic         ovf;
    metrics_t     m;
    case (w.mode)
      fem_pkg::MODE_RECORD: begin
        lvl = (w.pseudo || w.base == '0) ? fem_pkg::ALL_ONES
                                         : scale_256(128'(w.fee), 128'(w.base));
        if (level_cnt >= CAPACITY) begin
          dropped = 1'b1;
        end else begin
          pos = level_cnt;
          while (pos > 0 && fee_levels[pos-1] > lvl) begin
            fee_levels[pos] = fee_levels[pos-1];
            pos--;
          end
          fee_levels[pos] = lvl;
          level_cnt++;
        end
      end
      fem_pkg::MODE_CLOSE: begin
        size = level_cnt;
        ovf = dropped;
        if (w.leap) begin
          lim = {16'd0, target_reg - 16'd1};
          grown = (size > min_txn_reg) ? size : 32'(min_txn_reg);
          exp_txns = 16'((grown < lim) ? grown : lim);
        end else if (size > exp_txns || size > target_reg) begin
          exp_txns = 16'(size);
        end
        if (size == 0) begin
          esc_mult = min_mul_reg;
        end else begin
          med = (65'(fee_levels[size/2]) + 65'(fee_levels[(size-1)/2]) + 65'd1) >> 1;
          med32 = (med > 65'hFFFF_FFFF) ? 32'hFFFF_FFFF : med[31:0];
          esc_mult = (med32 > min_mul_reg) ? med32 : min_mul_reg;
        end
        level_cnt = 0;
        dropped = 1'b0;
        m = '{64'd0, exp_txns, esc_mult, 16'(size), ovf};
        expected_metrics = {expected_metrics, m};
      end
      fem_pkg::MODE_QUERY: begin
        lvl = fem_pkg::BASE_LEVEL;
        if (w.open_n > exp_txns) begin
          den = 128'(exp_txns) * 128'(exp_txns);
          num = 128'(w.open_n) * 128'(w.open_n) * 128'(esc_mult);
          lvl = (den == 0) ? fem_pkg::ALL_ONES : scale_256(num, den);
        end
        m = '{lvl, exp_txns, esc_mult, 16'(level_cnt), dropped};
        expected_metrics = {expected_metrics, m};
      end
      default: ;
    endcase
  endfunction

  // Sample at the rising edge: check results first, since a word taken at
  // this same edge can only produce a later result.
  always @(posedge clk_i) begin
    word_taken = in_valid_i && in_ready_o;
    metrics_taken = out_valid_o && out_ready_i;
    if (metrics_taken) begin
      if (expected_metrics.size() == 0) begin
        $error("result with nothing expected: level %0h", required_level_o);
        failed = 1'b1;
      end else begin
        metrics_t m;
        m = expected_metrics.pop_front();
        if (required_level_o !== m.required) begin
          $error("required_level exp %0h got %0h", m.required, required_level_o);
          failed = 1'b1;
        end
        if (expected_count_o !== m.expected) begin
          $error("expected_count exp %0d got %0d", m.expected, expected_count_o);
          failed = 1'b1;
        end
        if (multiplier_now_o !== m.mult) begin
          $error("multiplier_now exp %0d got %0d", m.mult, multiplier_now_o);
          failed = 1'b1;
        end
        if (ledger_size_o !== m.size) begin
          $error("ledger_size exp %0d got %0d", m.size, ledger_size_o);
          failed = 1'b1;
        end
        if (store_overflow_o !== m.ovf) begin
          $error("store_overflow exp %0b got %0b", m.ovf, store_overflow_o);
          failed = 1'b1;
        end
      end
    end
    if (word_taken)
      predict_word(word_t'{fem_pkg::mode_e'(mode_i), fee_drops_i, base_fee_drops_i,
                           is_pseudo_i, time_leap_i, open_count_i});
    if (word_taken || metrics_taken || cfg_we_i) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Sender: hold the word until taken, then idle a random count of cycles.
  int unsigned send_gap = 0;
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || word_taken)) begin
      if (send_gap > 0) begin
        send_gap--;
        in_valid_i <= 1'b0;
      end else if (pending_words.size() != 0) begin
        word_t w;
        w = pending_words.pop_front();
        mode_i <= w.mode;
        fee_drops_i <= w.fee;
        base_fee_drops_i <= w.base;
        is_pseudo_i <= w.pseudo;
        time_leap_i <= w.leap;
        open_count_i <= w.open_n;
        in_valid_i <= 1'b1;
        send_gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 15);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver: stall a random count of cycles after each taken result.
  int unsigned recv_stall = 0;
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (metrics_taken)
        recv_stall = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 15);
      if (recv_stall > 0) begin
        recv_stall--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  function automatic logic [56:0] rand_drops();
    logic [63:0] raw;
    int unsigned w;
    raw = {$urandom, $urandom};
    w = $urandom_range(0, 57);
    return 57'(raw & ((64'd1 << w) - 64'd1));
  endfunction

  task automatic queue_word(fem_pkg::mode_e md, logic [56:0] fee, logic [56:0] base,
                            logic pseudo, logic leap, logic [15:0] n);
    pending_words = {pending_words, word_t'{md, fee, base, pseudo, leap, n}};
    if (md != fem_pkg::MODE_NONE) words_queued++;
  endtask

  task automatic queue_record();
    logic [56:0] base;
    base = ($urandom_range(0, 15) == 0) ? 57'd0 : rand_drops();
    queue_word(fem_pkg::MODE_RECORD, rand_drops(), base, $urandom_range(0, 15) == 0,
               1'($urandom), 16'($urandom));
  endtask

  task automatic queue_query();
    logic [15:0] n;
    n = ($urandom_range(0, 4) == 0) ? 16'($urandom)
                                    : 16'($urandom_range(0, 3 * exp_txns + 8));
    queue_word(fem_pkg::MODE_QUERY, rand_drops(), rand_drops(), 1'($urandom),
               1'($urandom), n);
  endtask

  // One ledger: records with queries and ignored words mixed in, then a close and a query.
  task automatic queue_ledger(int unsigned n_rec);
    for (int unsigned i = 0; i < n_rec; i++) begin
      queue_record();
      if ($urandom_range(0, 5) == 0) queue_query();
      if ($urandom_range(0, 19) == 0)
        queue_word(fem_pkg::MODE_NONE, rand_drops(), rand_drops(), 1'($urandom),
                   1'($urandom), 16'($urandom));
    end
    queue_word(fem_pkg::MODE_CLOSE, rand_drops(), rand_drops(), 1'($urandom),
               $urandom_range(0, 3) == 0, 16'($urandom));
    queue_query();
  endtask

  task automatic drain();
    while (pending_words.size() != 0 || in_valid_i || expected_metrics.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(fem_pkg::reg_e idx, logic [31:0] data);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = data;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      fem_pkg::REG_TARGET:  target_reg = data[15:0];
      fem_pkg::REG_MIN_TXN: min_txn_reg = data[15:0];
      fem_pkg::REG_MIN_MUL: min_mul_reg = data;
      default: ;
    endcase
  endtask

  initial begin
    logic [31:0] tgt [6];
    logic [31:0] mtx [6];
    logic [31:0] mml [6];
    int unsigned goal;
    tgt = '{32'd50, 32'd0, 32'd65535, 32'd1, 32'd20, 32'd300};
    mtx = '{32'd5, 32'd0, 32'd65535, 32'd3, 32'd0, 32'd40};
    mml = '{32'd500, 32'd0, 32'hFFFF_FFFF, 32'd256, 32'd1, 32'd100000};
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: field extremes, each mode, pseudo and zero base, saturation.
    queue_word(fem_pkg::MODE_QUERY, '0, '0, 1'b0, 1'b0, 16'd0);
    queue_word(fem_pkg::MODE_QUERY, '0, '0, 1'b0, 1'b0, 16'hFFFF);
    queue_word(fem_pkg::MODE_CLOSE, '0, '0, 1'b0, 1'b0, 16'd0);
    queue_word(fem_pkg::MODE_RECORD, '1, 57'd1, 1'b0, 1'b0, 16'd0);
    queue_word(fem_pkg::MODE_RECORD, '1, '1, 1'b0, 1'b1, 16'hFFFF);
    queue_word(fem_pkg::MODE_RECORD, 57'd0, 57'd7, 1'b0, 1'b0, 16'd0);
    queue_word(fem_pkg::MODE_RECORD, 57'd5, 57'd0, 1'b0, 1'b0, 16'd0);
    queue_word(fem_pkg::MODE_RECORD, 57'd1000, 57'd10, 1'b1, 1'b0, 16'd0);
    queue_word(fem_pkg::MODE_NONE, '1, '1, 1'b1, 1'b1, 16'hFFFF);
    queue_word(fem_pkg::MODE_QUERY, '1, '1, 1'b1, 1'b1, 16'd6);
    queue_word(fem_pkg::MODE_CLOSE, '1, '1, 1'b1, 1'b1, 16'hFFFF);
    queue_word(fem_pkg::MODE_RECORD, 57'd3, 57'd2, 1'b0, 1'b0, 16'd0);
    queue_word(fem_pkg::MODE_RECORD, 57'd9, 57'd4, 1'b0, 1'b0, 16'd0);
    queue_word(fem_pkg::MODE_CLOSE, '0, '0, 1'b0, 1'b0, 16'd0);
    queue_word(fem_pkg::MODE_QUERY, '0, '0, 1'b0, 1'b0, 16'd400);
    drain();

    for (int p = 0; p < 6; p++) begin
      if (p != 0) begin
        write_reg(fem_pkg::REG_TARGET, tgt[p]);
        write_reg(fem_pkg::REG_MIN_TXN, mtx[p]);
        write_reg(fem_pkg::REG_MIN_MUL, mml[p]);
        // Empty ledger with a leap: pulls the expected count onto the limits.
        queue_word(fem_pkg::MODE_CLOSE, '0, '0, 1'b0, 1'b1, 16'd0);
        queue_query();
      end
      // Overflow the store once, in a setting with a small target.
      if (p == 3) queue_ledger(CAPACITY + 4);
      goal = words_queued + 80;
      while (words_queued < goal)
        queue_ledger(($urandom_range(0, 7) == 0) ? $urandom_range(13, 60)
                                                 : $urandom_range(0, 12));
      drain();
    end

    if (!failed) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
`default_nettype wire
